@@ hw/rtl/imh_pkg.sv @@
// ----------------------------------------------------------------------------
// imh_pkg
// Shared types and codes for the indexed max-heap.
// ----------------------------------------------------------------------------
package imh_pkg;

    localparam int ID_BITS = 10;

    localparam logic [1:0] FUNC_INSERT  = 2'd0;
    localparam logic [1:0] FUNC_CHANGE  = 2'd1;
    localparam logic [1:0] FUNC_EXTRACT = 2'd2;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_DUP   = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_SAME  = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic [ID_BITS-1:0] node_id;
        logic signed [31:0] key_value;
    } req_t;

    typedef struct packed {
        logic [ID_BITS-1:0] out_node;
        logic signed [31:0] out_key;
        logic [1:0]         status;
        logic               was_present;
        logic               heap_empty;
    } res_t;

endpackage

@@ hw/rtl/imh_if.sv @@
// ----------------------------------------------------------------------------
// imh_if
// Valid/ready channels for heap requests and results.
// ----------------------------------------------------------------------------
interface imh_req_if;
    import imh_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          func;
    logic [ID_BITS-1:0]  node_id;
    logic signed [31:0]  key_value;
    modport source (output valid, func, node_id, key_value, input ready);
    modport sink   (input valid, func, node_id, key_value, output ready);
endinterface

interface imh_res_if;
    import imh_pkg::*;
    logic                valid;
    logic                ready;
    logic [ID_BITS-1:0]  out_node;
    logic signed [31:0]  out_key;
    logic [1:0]          status;
    logic                was_present;
    logic                heap_empty;
    modport source (output valid, out_node, out_key, status, was_present, heap_empty,
                    input ready);
    modport sink   (input valid, out_node, out_key, status, was_present, heap_empty,
                    output ready);
endinterface

@@ hw/rtl/imh_core.sv @@
// ----------------------------------------------------------------------------
// imh_core
// Heap sequencer: slot memory, position map, sift up/down by moving a hole.
// ----------------------------------------------------------------------------
module imh_core
    import imh_pkg::*;
#(
    parameter int MAX_NODES = 1024,
    parameter int KEY_BITS  = 32
)(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    input  logic res_room,
    output logic idle,
    output logic done,
    output res_t res
);

    localparam int SW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int EW = ID_BITS + KEY_BITS;
    localparam int XW = (KEY_BITS > 32) ? KEY_BITS : 32;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_EXRD = 4'd2;
    localparam logic [3:0] S_LK   = 4'd3;
    localparam logic [3:0] S_CKRD = 4'd4;
    localparam logic [3:0] S_UP   = 4'd5;
    localparam logic [3:0] S_UPW  = 4'd6;
    localparam logic [3:0] S_DN   = 4'd7;
    localparam logic [3:0] S_DNW  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [EW-1:0] slot_mem [MAX_NODES];
    logic [SW:0]   map_mem  [MAX_NODES];

    logic [3:0]          state_reg, state_next;
    logic [1:0]          func_reg, func_next;
    logic [ID_BITS-1:0]  node_reg, node_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [SW-1:0]       hole_reg, hole_next;
    logic [SW:0]         count_reg, count_next;
    logic [SW-1:0]       clr_reg, clr_next;
    logic [1:0]          status_reg, status_next;
    logic                present_reg, present_next;
    logic [ID_BITS-1:0]  onode_reg, onode_next;
    logic [KEY_BITS-1:0] okey_reg, okey_next;

    logic [SW-1:0] ra_addr, rb_addr, sw_addr, mr_addr, mw_addr;
    logic [EW-1:0] ra_data, rb_data, sw_data;
    logic [SW:0]   mr_data, mw_data;
    logic          sw_en, mw_en;

    logic signed [XW-1:0] key_x, okey_x;
    logic [KEY_BITS-1:0]  key_in, ra_key, rb_key, big_key;
    logic [ID_BITS-1:0]   ra_node, rb_node;
    logic [SW:0]          cnt_m1, l_idx;
    logic [SW+1:0]        r_idx;
    logic [SW-1:0]        parent;
    logic                 node_ok, take_l, take_r;

    always_ff @(posedge clk)
    begin
        if (sw_en)
        begin
            slot_mem[sw_addr] <= sw_data;
        end
        ra_data <= slot_mem[ra_addr];
        rb_data <= slot_mem[rb_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mw_en)
        begin
            map_mem[mw_addr] <= mw_data;
        end
        mr_data <= map_mem[mr_addr];
    end

    assign key_x   = XW'($signed(req.key_value));
    assign key_in  = key_x[KEY_BITS-1:0];
    assign ra_key  = ra_data[KEY_BITS-1:0];
    assign rb_key  = rb_data[KEY_BITS-1:0];
    assign ra_node = ra_data[EW-1:KEY_BITS];
    assign rb_node = rb_data[EW-1:KEY_BITS];
    assign cnt_m1  = count_reg - (SW+1)'(1);
    assign parent  = (hole_reg - SW'(1)) >> 1;
    assign l_idx   = {hole_reg, 1'b1};
    assign r_idx   = {1'b0, hole_reg, 1'b0} + (SW+2)'(2);
    assign node_ok = ({22'd0, req.node_id} < 32'(MAX_NODES));
    assign take_l  = $signed(key_reg) < $signed(ra_key);
    assign big_key = take_l ? ra_key : key_reg;
    assign take_r  = (r_idx < {1'b0, count_reg}) && ($signed(big_key) < $signed(rb_key));

    always_comb
    begin
        state_next   = state_reg;
        func_next    = func_reg;
        node_next    = node_reg;
        key_next     = key_reg;
        hole_next    = hole_reg;
        count_next   = count_reg;
        clr_next     = clr_reg;
        status_next  = status_reg;
        present_next = present_reg;
        onode_next   = onode_reg;
        okey_next    = okey_reg;
        ra_addr      = '0;
        rb_addr      = '0;
        mr_addr      = '0;
        sw_en        = 1'b0;
        sw_addr      = hole_reg;
        sw_data      = {node_reg, key_reg};
        mw_en        = 1'b0;
        mw_addr      = '0;
        mw_data      = '0;
        done         = 1'b0;
        unique case (state_reg)
            S_CLR:
            begin
                mw_en    = 1'b1;
                mw_addr  = clr_reg;
                clr_next = clr_reg + SW'(1);
                if (clr_reg == SW'(MAX_NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                ra_addr = '0;
                rb_addr = cnt_m1[SW-1:0];
                mr_addr = SW'(req.node_id);
                if (start)
                begin
                    func_next    = req.func;
                    node_next    = req.node_id;
                    key_next     = key_in;
                    status_next  = STAT_DONE;
                    present_next = 1'b0;
                    onode_next   = '0;
                    okey_next    = '0;
                    if (req.func == FUNC_EXTRACT)
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STAT_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_EXRD;
                        end
                    end
                    else if ((req.func == FUNC_INSERT || req.func == FUNC_CHANGE) && node_ok)
                    begin
                        state_next = S_LK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_EXRD:
            begin
                onode_next   = ra_node;
                okey_next    = ra_key;
                present_next = 1'b1;
                mw_en        = 1'b1;
                mw_addr      = SW'(ra_node);
                count_next   = cnt_m1;
                node_next    = rb_node;
                key_next     = rb_key;
                hole_next    = '0;
                state_next   = (cnt_m1 == '0) ? S_DONE : S_DN;
            end
            S_LK:
            begin
                if (!mr_data[SW])
                begin
                    if (count_reg < (SW+1)'(MAX_NODES))
                    begin
                        hole_next  = count_reg[SW-1:0];
                        count_next = count_reg + (SW+1)'(1);
                        state_next = S_UP;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    present_next = 1'b1;
                    if (func_reg == FUNC_INSERT)
                    begin
                        status_next = STAT_DUP;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        hole_next  = mr_data[SW-1:0];
                        ra_addr    = mr_data[SW-1:0];
                        state_next = S_CKRD;
                    end
                end
            end
            S_CKRD:
            begin
                if (ra_key == key_reg)
                begin
                    status_next = STAT_SAME;
                    state_next  = S_DONE;
                end
                else if ($signed(ra_key) < $signed(key_reg))
                begin
                    state_next = S_UP;
                end
                else
                begin
                    state_next = S_DN;
                end
            end
            S_UP:
            begin
                ra_addr    = parent;
                state_next = (hole_reg == '0) ? S_FIN : S_UPW;
            end
            S_UPW:
            begin
                if ($signed(ra_key) < $signed(key_reg))
                begin
                    sw_en      = 1'b1;
                    sw_data    = ra_data;
                    mw_en      = 1'b1;
                    mw_addr    = SW'(ra_node);
                    mw_data    = {1'b1, hole_reg};
                    hole_next  = parent;
                    state_next = S_UP;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DN:
            begin
                ra_addr    = l_idx[SW-1:0];
                rb_addr    = r_idx[SW-1:0];
                state_next = (l_idx < count_reg) ? S_DNW : S_FIN;
            end
            S_DNW:
            begin
                if (take_r)
                begin
                    sw_en      = 1'b1;
                    sw_data    = rb_data;
                    mw_en      = 1'b1;
                    mw_addr    = SW'(rb_node);
                    mw_data    = {1'b1, hole_reg};
                    hole_next  = r_idx[SW-1:0];
                    state_next = S_DN;
                end
                else if (take_l)
                begin
                    sw_en      = 1'b1;
                    sw_data    = ra_data;
                    mw_en      = 1'b1;
                    mw_addr    = SW'(ra_node);
                    mw_data    = {1'b1, hole_reg};
                    hole_next  = l_idx[SW-1:0];
                    state_next = S_DN;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                sw_en      = 1'b1;
                mw_en      = 1'b1;
                mw_addr    = SW'(node_reg);
                mw_data    = {1'b1, hole_reg};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_room)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            count_reg <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        node_reg    <= node_next;
        key_reg     <= key_next;
        hole_reg    <= hole_next;
        status_reg  <= status_next;
        present_reg <= present_next;
        onode_reg   <= onode_next;
        okey_reg    <= okey_next;
    end

    assign okey_x          = XW'($signed(okey_reg));
    assign idle            = (state_reg == S_IDLE);
    assign res.out_node    = onode_reg;
    assign res.out_key     = okey_x[31:0];
    assign res.status      = status_reg;
    assign res.was_present = present_reg;
    assign res.heap_empty  = (count_reg == '0);

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (SW+1)'(MAX_NODES))
        else $error("entry count above capacity");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == S_IDLE)
        else $error("request started while busy");

    a_hole_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP || state_reg == S_DN || state_reg == S_FIN)
            |-> {1'b0, hole_reg} < count_reg)
        else $error("hole outside heap");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> state_reg == S_IDLE)
        else $error("result without return to idle");

endmodule

@@ hw/rtl/indexed_max_heap_top.sv @@
// ----------------------------------------------------------------------------
// indexed_max_heap_top
// Addressable binary max-heap of node ids with signed keys.
// ----------------------------------------------------------------------------
// Request channel req: func (insert, change key or insert, extract max),
// node_id and key_value. Result channel res: one result per request with
// out_node, out_key, status, was_present and heap_empty.
// One request is handled at a time. The sift walks the heap one level at a
// time, reading the registered slot memory for each level it moves through.
// After reset the position map is cleared, one entry a cycle; req.ready
// stays low during that pass.
// A finished result sits in an output register; a new request is taken
// while it waits. If the receiver stalls with a second result ready, the
// sequencer holds until the output register frees.
// ----------------------------------------------------------------------------
module indexed_max_heap_top
    import imh_pkg::*;
#(
    parameter int MAX_NODES = 1024,
    parameter int KEY_BITS  = 32
)(
    input  logic      clk,
    input  logic      rst_n,
    imh_req_if.sink   req,
    imh_res_if.source res
);

    req_t core_req;
    res_t core_res;
    res_t res_reg;
    logic out_valid_reg, out_valid_next;
    logic core_idle, core_done, res_room, start;

    assign core_req.func      = req.func;
    assign core_req.node_id   = req.node_id;
    assign core_req.key_value = req.key_value;
    assign req.ready          = core_idle;
    assign start              = req.valid && core_idle;
    assign res_room           = !out_valid_reg || res.ready;

    imh_core #(
        .MAX_NODES (MAX_NODES),
        .KEY_BITS  (KEY_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (core_req),
        .res_room (res_room),
        .idle     (core_idle),
        .done     (core_done),
        .res      (core_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (core_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_done)
        begin
            res_reg <= core_res;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.out_node    = res_reg.out_node;
    assign res.out_key     = res_reg.out_key;
    assign res.status      = res_reg.status;
    assign res.was_present = res_reg.was_present;
    assign res.heap_empty  = res_reg.heap_empty;

endmodule
